// ===== design/pcc_pkg.sv =====
// shared types, constants and the arctangent table of the polar/cartesian converter
// no dependencies
package pcc_pkg;

  localparam int ZW = 26;          // cordic angle accumulator, holds up to 24-bit turns
  localparam int CW = 36;          // cordic x/y datapath
  localparam int SQ_STEPS = 33;    // root digits of a 66-bit radicand
  localparam logic [31:0] GAIN = 32'h9B74EDA8;

  localparam logic CMD_POINTS = 1'b0;
  localparam logic CMD_VECTOR = 1'b1;

  localparam logic [15:0] ANG_EAST  = 16'd0;
  localparam logic [15:0] ANG_NORTH = 16'd16384;
  localparam logic [15:0] ANG_WEST  = 16'd32768;
  localparam logic [15:0] ANG_SOUTH = 16'd49152;

  localparam logic [31:0] ATAN_TURN32 [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic               command;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic [31:0]        length;
    logic [15:0]        direction;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        angle;
    logic [32:0]        distance;
    logic               coincident;
    logic signed [31:0] result_x;
    logic signed [31:0] result_y;
  } out_item_t;

  // one slot of the sqrt / cordic pipeline
  typedef struct packed {
    logic               cmd;
    logic               coinc;
    logic               ang_fix;
    logic [15:0]        ang_val;
    logic               rot_fix;
    logic [1:0]         quad;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [31:0]        len;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [65:0]        rad;
    logic [35:0]        rem;
    logic [32:0]        root;
  } pcc_pipe_t;

  // atan(2^-i) rounded to an aw-bit turn
  function automatic logic [31:0] step_angle(int i, int aw);
    int          s;
    logic [32:0] t;
    s = 32 - aw;
    t = {1'b0, ATAN_TURN32[i]} + (33'd1 << (s - 1));
    return t[32:1] >> (s - 1);
  endfunction

endpackage

// ===== design/pcc_front.sv =====
// front end: differences, gain and square multipliers, radicand sum, cordic setup
// depends on pcc_pkg
module pcc_front #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  pcc_pkg::in_item_t  in_item,
  output logic               out_valid,
  output pcc_pkg::pcc_pipe_t out_pipe
);
  import pcc_pkg::*;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [31:0]        ax;
    logic [31:0]        ay;
    logic [31:0]        len;
    logic [15:0]        dir;
    logic [63:0]        gprod;
  } pcc_a_t;

  typedef struct packed {
    pcc_pipe_t   p;
    logic [63:0] sq1;
    logic [63:0] sq2;
  } pcc_b_t;

  pcc_a_t a_nxt, a_r;
  pcc_b_t b_nxt, b_r;
  pcc_pipe_t c_nxt, c_r;
  logic a_vld_r, b_vld_r, c_vld_r;

  always_comb begin
    logic signed [32:0] dx, dy;
    dx = {in_item.end_x[31], in_item.end_x} - {in_item.start_x[31], in_item.start_x};
    dy = {in_item.end_y[31], in_item.end_y} - {in_item.start_y[31], in_item.start_y};
    a_nxt.cmd   = in_item.command;
    a_nxt.sx    = in_item.start_x;
    a_nxt.sy    = in_item.start_y;
    a_nxt.dx    = dx;
    a_nxt.dy    = dy;
    a_nxt.ax    = dx[32] ? 32'(-dx) : dx[31:0];
    a_nxt.ay    = dy[32] ? 32'(-dy) : dy[31:0];
    a_nxt.len   = in_item.length;
    a_nxt.dir   = in_item.direction;
    a_nxt.gprod = 64'(in_item.length) * 64'(GAIN);
  end

  localparam int FSHL = (ANGLE_WIDTH >= 16) ? ANGLE_WIDTH - 16 : 0;
  localparam int FSHR = (ANGLE_WIDTH < 16) ? 16 - ANGLE_WIDTH : 1;

  always_comb begin
    logic [64:0]          mr;
    logic signed [CW-1:0] m, dxe, dye;
    logic [ZW-1:0]        zf;
    mr  = {1'b0, a_r.gprod} + 65'h80000000;
    m   = CW'(mr[63:32]);
    dxe = CW'(a_r.dx);
    dye = CW'(a_r.dy);
    if (ANGLE_WIDTH >= 16) begin
      zf = ZW'(a_r.dir[13:0]) << FSHL;
    end else begin
      zf = (ZW'(a_r.dir[13:0]) + (ZW'(1) << (FSHR - 1))) >> FSHR;
    end
    b_nxt.sq1 = 64'(a_r.ax) * 64'(a_r.ax);
    b_nxt.sq2 = 64'(a_r.ay) * 64'(a_r.ay);
    b_nxt.p.cmd   = a_r.cmd;
    b_nxt.p.coinc = (a_r.dx == '0) && (a_r.dy == '0);
    b_nxt.p.ang_fix = (a_r.dx == '0) || (a_r.dy == '0);
    if (a_r.dx == '0) begin
      b_nxt.p.ang_val = (a_r.dy > 0) ? ANG_NORTH : ANG_SOUTH;
    end else begin
      b_nxt.p.ang_val = (a_r.dx > 0) ? ANG_EAST : ANG_WEST;
    end
    b_nxt.p.rot_fix = (a_r.dir[13:0] == '0);
    b_nxt.p.quad    = a_r.dir[15:14];
    b_nxt.p.sx  = a_r.sx;
    b_nxt.p.sy  = a_r.sy;
    b_nxt.p.len = a_r.len;
    b_nxt.p.rad  = '0;
    b_nxt.p.rem  = '0;
    b_nxt.p.root = '0;
    if (a_r.cmd == CMD_POINTS) begin
      // fold the left half plane over, starting half a turn in
      if (a_r.dx < 0) begin
        b_nxt.p.x = -dxe;
        b_nxt.p.y = -dye;
        b_nxt.p.z = ZW'(1) << (ANGLE_WIDTH - 1);
      end else begin
        b_nxt.p.x = dxe;
        b_nxt.p.y = dye;
        b_nxt.p.z = '0;
      end
    end else begin
      unique case (a_r.dir[15:14])
        2'd0: begin b_nxt.p.x = m;  b_nxt.p.y = '0; end
        2'd1: begin b_nxt.p.x = '0; b_nxt.p.y = m;  end
        2'd2: begin b_nxt.p.x = -m; b_nxt.p.y = '0; end
        default: begin b_nxt.p.x = '0; b_nxt.p.y = -m; end
      endcase
      b_nxt.p.z = signed'(zf);
    end
  end

  always_comb begin
    c_nxt = b_r.p;
    c_nxt.rad = {1'b0, {1'b0, b_r.sq1} + {1'b0, b_r.sq2}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
  end

  assign out_valid = c_vld_r;
  assign out_pipe  = c_r;

endmodule

// ===== design/pcc_stage.sv =====
// one pipeline stage: a root digit and, in the first stages, a cordic micro-rotation
// depends on pcc_pkg
module pcc_stage #(
  parameter int IDX = 0,
  parameter int ITERATIONS = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  pcc_pkg::pcc_pipe_t in_pipe,
  output logic               out_valid,
  output pcc_pkg::pcc_pipe_t out_pipe
);
  import pcc_pkg::*;

  localparam int P = 64 - 2 * IDX;

  pcc_pipe_t pipe_nxt, pipe_r;
  logic      vld_r;

  always_comb begin
    logic [35:0]          rem_w, trial;
    logic signed [CW-1:0] xs, ys;
    logic signed [ZW-1:0] st;
    pipe_nxt = in_pipe;
    rem_w = {in_pipe.rem[33:0], in_pipe.rad[P+1:P]};
    trial = {1'b0, in_pipe.root, 2'b01};
    if (rem_w >= trial) begin
      pipe_nxt.rem  = rem_w - trial;
      pipe_nxt.root = {in_pipe.root[31:0], 1'b1};
    end else begin
      pipe_nxt.rem  = rem_w;
      pipe_nxt.root = {in_pipe.root[31:0], 1'b0};
    end
    xs = in_pipe.x >>> IDX;
    ys = in_pipe.y >>> IDX;
    st = signed'(ZW'(step_angle(IDX % 32, ANGLE_WIDTH)));
    if (IDX < ITERATIONS) begin
      if (in_pipe.cmd == CMD_POINTS) begin
        if (in_pipe.y > 0) begin
          pipe_nxt.x = in_pipe.x + ys;
          pipe_nxt.y = in_pipe.y - xs;
          pipe_nxt.z = in_pipe.z + st;
        end else begin
          pipe_nxt.x = in_pipe.x - ys;
          pipe_nxt.y = in_pipe.y + xs;
          pipe_nxt.z = in_pipe.z - st;
        end
      end else begin
        if (in_pipe.z >= 0) begin
          pipe_nxt.x = in_pipe.x - ys;
          pipe_nxt.y = in_pipe.y + xs;
          pipe_nxt.z = in_pipe.z - st;
        end else begin
          pipe_nxt.x = in_pipe.x + ys;
          pipe_nxt.y = in_pipe.y - xs;
          pipe_nxt.z = in_pipe.z + st;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_valid;
    end
    pipe_r <= pipe_nxt;
  end

  assign out_valid = vld_r;
  assign out_pipe  = pipe_r;

endmodule

// ===== design/pcc_back.sv =====
// back end: root rounding, angle scaling, end point saturation, result register
// depends on pcc_pkg
module pcc_back #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  pcc_pkg::pcc_pipe_t in_pipe,
  output logic               out_strobe,
  output pcc_pkg::out_item_t out_item
);
  import pcc_pkg::*;

  localparam int SHR = (ANGLE_WIDTH > 16) ? ANGLE_WIDTH - 16 : 1;
  localparam int SHL = (ANGLE_WIDTH < 16) ? 16 - ANGLE_WIDTH : 0;

  out_item_t item_nxt, item_r;
  logic      strobe_r;

  function automatic logic signed [31:0] sat32(logic signed [36:0] v);
    if (v > 37'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -37'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  always_comb begin
    logic [24:0]          zu;
    logic [15:0]          a16;
    logic [32:0]          root_rnd;
    logic signed [CW-1:0] rx, ry, l;
    zu = 25'(in_pipe.z[ANGLE_WIDTH-1:0]);
    if (ANGLE_WIDTH > 16) begin
      a16 = 16'((zu + (25'd1 << (SHR - 1))) >> SHR);
    end else begin
      a16 = 16'(zu << SHL);
    end
    root_rnd = (36'(in_pipe.rem) > 36'(in_pipe.root)) ? in_pipe.root + 33'd1 : in_pipe.root;
    l = CW'(in_pipe.len);
    if (in_pipe.rot_fix) begin
      unique case (in_pipe.quad)
        2'd0: begin rx = l;   ry = '0;  end
        2'd1: begin rx = '0;  ry = l;   end
        2'd2: begin rx = -l;  ry = '0;  end
        default: begin rx = '0; ry = -l; end
      endcase
    end else begin
      rx = in_pipe.x;
      ry = in_pipe.y;
    end
    item_nxt = '0;
    if (in_pipe.cmd == CMD_POINTS) begin
      if (in_pipe.coinc) begin
        item_nxt.coincident = 1'b1;
      end else begin
        item_nxt.angle    = in_pipe.ang_fix ? in_pipe.ang_val : a16;
        item_nxt.distance = root_rnd;
      end
    end else begin
      item_nxt.result_x = sat32(37'(in_pipe.sx) + 37'(rx));
      item_nxt.result_y = sat32(37'(in_pipe.sy) + 37'(ry));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= in_valid;
    end
    item_r <= item_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

endmodule

// ===== design/polar_cartesian_converter_top.sv =====
// top level of the polar/cartesian converter: front end, sqrt/cordic stage chain, back end
// depends on pcc_pkg, pcc_front, pcc_stage, pcc_back
//
// Command channel: drive in_item and raise start; the item transfers at a rising
// edge with start high and busy low. busy is high while rst_n is low and drops at the
// first rising edge after reset is released, so from then on an item can be sent in every cycle.
// Command 0 (two points) returns the direction start to end (65536 = full turn),
// the rounded distance and a coincident flag; command 1 (vector) returns the end
// point, saturated to the signed Q16.16 range.
// Result channel: out_strobe is high for exactly one cycle with out_item valid;
// the receiver cannot stall, results leave in the order items came in.
// Path: an item passes the three front stages, then the 33 square root digit stages
// (one digit per stage), then the back end result register; the cordic runs beside
// the first ITERATIONS of the digit stages. Throughput: one item per cycle while
// busy is low.
// Reset (rst_n low, synchronous) empties the pipeline; items in flight are dropped.
module polar_cartesian_converter_top #(
  parameter int ITERATIONS = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pcc_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output pcc_pkg::out_item_t out_item
);
  import pcc_pkg::*;

  localparam int LAT = SQ_STEPS + 4;

  pcc_pipe_t pipe [SQ_STEPS+1];
  logic      vld  [SQ_STEPS+1];
  logic      busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  pcc_front #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy_r),
    .in_item  (in_item),
    .out_valid(vld[0]),
    .out_pipe (pipe[0])
  );

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_stage
    pcc_stage #(
      .IDX        (k),
      .ITERATIONS (ITERATIONS),
      .ANGLE_WIDTH(ANGLE_WIDTH)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (vld[k]),
      .in_pipe  (pipe[k]),
      .out_valid(vld[k+1]),
      .out_pipe (pipe[k+1])
    );
  end

  pcc_back #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld[SQ_STEPS]),
    .in_pipe   (pipe[SQ_STEPS]),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_strobe)
    else $error("result missing after fixed latency");

  a_coinc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.coincident) |->
      (out_item.angle == '0 && out_item.distance == '0))
    else $error("coincident result carries angle or distance");

  a_coinc_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.coincident) |->
      (out_item.result_x == '0 && out_item.result_y == '0))
    else $error("coincident flag on a vector result");

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench of polar_cartesian_converter_top: directed table, then random items
// depends on pcc_pkg and the converter rtl; carries its own cordic and square root model
`timescale 1ns / 100ps

module testbench;
  import pcc_pkg::*;

  localparam int ITER = 16;
  localparam int AW = 16;
  localparam int N_RANDOM = 1300;
  localparam int LATENCY = 37;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    in_item_t item;
    logic     typed;
    out_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_item = '0;
  logic out_strobe;
  out_item_t out_item;

  out_item_t expected_q[$];
  int errors = 0;
  longint cycles = 0;

  polar_cartesian_converter_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_strobe(out_strobe), .out_item(out_item)
  );

  always #5 clk = ~clk;

  // arithmetic shift, rounds toward minus infinity
  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_step(int i);
    int s;
    longint t;
    s = 32 - AW;
    t = longint'(ATAN_TURN32[i]);
    return (t + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [15:0] points_angle(longint dx, longint dy);
    longint x, y, z, xs, ys;
    x = dx; y = dy; z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 64'sd1 <<< (AW - 1);
    end
    for (int i = 0; i < ITER; i++) begin
      xs = shr(x, i); ys = shr(y, i);
      if (y > 0) begin
        x += ys; y -= xs; z += atan_step(i);
      end else begin
        x -= ys; y += xs; z -= atan_step(i);
      end
    end
    return z[15:0];
  endfunction

  // rounded integer square root of a 66-bit radicand
  function automatic logic [32:0] rounded_root(logic [65:0] rad);
    logic [67:0] root, rem, trial;
    root = 0; rem = 0;
    for (int p = 64; p >= 0; p -= 2) begin
      rem = (rem << 2) | rad[p +: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem -= trial; root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    if (rem > root) root += 1;
    return root[32:0];
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic out_item_t convert(in_item_t it);
    out_item_t r;
    longint dx, dy, rx, ry, m, x, y, z, xs, ys, l;
    logic [65:0] sq;
    logic [1:0] q;
    r = '0;
    if (it.command == CMD_POINTS) begin
      dx = longint'(it.end_x) - longint'(it.start_x);
      dy = longint'(it.end_y) - longint'(it.start_y);
      if (dx == 0 && dy == 0) begin
        r.coincident = 1'b1;
        return r;
      end
      if (dx == 0) r.angle = (dy > 0) ? ANG_NORTH : ANG_SOUTH;
      else if (dy == 0) r.angle = (dx > 0) ? ANG_EAST : ANG_WEST;
      else r.angle = points_angle(dx, dy);
      sq = 66'(dx * dx) + 66'(dy * dy);
      if (dx * dx < 0 || dy * dy < 0) begin
        // squares up to 2^64 overflow longint; redo them unsigned
        sq = 66'((dx < 0 ? -dx : dx)) * 66'((dx < 0 ? -dx : dx))
           + 66'((dy < 0 ? -dy : dy)) * 66'((dy < 0 ? -dy : dy));
      end else begin
        sq = 66'((dx < 0 ? -dx : dx)) * 66'((dx < 0 ? -dx : dx))
           + 66'((dy < 0 ? -dy : dy)) * 66'((dy < 0 ? -dy : dy));
      end
      r.distance = rounded_root(sq);
    end else begin
      l = longint'({32'd0, it.length});
      case (it.direction)
        ANG_EAST:  begin rx = l; ry = 0; end
        ANG_NORTH: begin rx = 0; ry = l; end
        ANG_WEST:  begin rx = -l; ry = 0; end
        ANG_SOUTH: begin rx = 0; ry = -l; end
        default: begin
          m = longint'((64'(it.length) * 64'(GAIN) + 64'h80000000) >> 32);
          q = it.direction[15:14];
          x = (q == 0) ? m : (q == 2) ? -m : 0;
          y = (q == 1) ? m : (q == 3) ? -m : 0;
          z = longint'({50'd0, it.direction[13:0]});
          for (int i = 0; i < ITER; i++) begin
            xs = shr(x, i); ys = shr(y, i);
            if (z >= 0) begin
              x -= ys; y += xs; z -= atan_step(i);
            end else begin
              x += ys; y -= xs; z += atan_step(i);
            end
          end
          rx = x; ry = y;
        end
      endcase
      r.result_x = clamp32(longint'(it.start_x) + rx);
      r.result_y = clamp32(longint'(it.start_y) + ry);
    end
    return r;
  endfunction

  function automatic in_item_t pts(logic [31:0] sx, logic [31:0] sy,
                                   logic [31:0] ex, logic [31:0] ey);
    in_item_t it;
    it = '0;
    it.command = CMD_POINTS;
    it.start_x = sx; it.start_y = sy; it.end_x = ex; it.end_y = ey;
    return it;
  endfunction

  function automatic in_item_t vec(logic [31:0] sx, logic [31:0] sy,
                                   logic [31:0] len, logic [15:0] dir);
    in_item_t it;
    it = '0;
    it.command = CMD_VECTOR;
    it.start_x = sx; it.start_y = sy; it.length = len; it.direction = dir;
    return it;
  endfunction

  function automatic out_item_t res(logic [15:0] a, logic [32:0] d, logic c,
                                    logic [31:0] x, logic [31:0] y);
    out_item_t r;
    r.angle = a; r.distance = d; r.coincident = c; r.result_x = x; r.result_y = y;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'(int'($urandom_range(0, 2000)) - 1000);
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 3)
                                     : 32'h80000000 + $urandom_range(0, 3);
      2: return 32'(int'($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000);
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    logic [31:0] sx, sy;
    sx = rand_coord(); sy = rand_coord();
    if ($urandom_range(0, 1)) begin
      it = pts(sx, sy, rand_coord(), rand_coord());
      case ($urandom_range(0, 9))
        0: it.end_x = sx;
        1: it.end_y = sy;
        2: begin it.end_x = sx; it.end_y = sy; end
        default: ;
      endcase
      it.length = $urandom(); it.direction = $urandom();
    end else begin
      it = vec(sx, sy, $urandom_range(0, 3) == 0 ? $urandom_range(0, 300) : $urandom(),
               $urandom_range(0, 7) == 0 ? 16'($urandom_range(0, 3) << 14) : 16'($urandom()));
      it.end_x = $urandom(); it.end_y = $urandom();
    end
    return it;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    repeat (n) @(negedge clk);
  endtask

  // one transfer: start is held until a rising edge sees busy low, then dropped for a cycle
  task automatic send(in_item_t it);
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_q.push_back(convert(it));
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
  endtask

  // same as send, with the expected result given by the table
  task automatic send_typed(in_item_t it, out_item_t want);
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_q.push_back(want);
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
  endtask

  // burst mode keeps start high across consecutive transfers
  task automatic send_burst(in_item_t it);
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_q.push_back(convert(it));
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    out_item_t w;
    cycles <= cycles + 1;
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result: actual %p", $time, out_item);
        errors++;
      end else begin
        w = expected_q.pop_front();
        if (out_item.angle !== w.angle)
          $display("%0t angle: expected %0d actual %0d", $time, w.angle, out_item.angle);
        if (out_item.distance !== w.distance)
          $display("%0t distance: expected %0d actual %0d", $time, w.distance,
                   out_item.distance);
        if (out_item.coincident !== w.coincident)
          $display("%0t coincident: expected %0d actual %0d", $time, w.coincident,
                   out_item.coincident);
        if (out_item.result_x !== w.result_x)
          $display("%0t result_x: expected %0d actual %0d", $time, w.result_x,
                   out_item.result_x);
        if (out_item.result_y !== w.result_y)
          $display("%0t result_y: expected %0d actual %0d", $time, w.result_y,
                   out_item.result_y);
        if (out_item !== w) errors++;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    rows = '{
      '{pts(0, 0, 0, 0), 1, res(0, 0, 1, 0, 0)},
      '{pts(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000), 1, res(0, 0, 1, 0, 0)},
      '{pts(0, 0, 32'h00010000, 0), 1, res(ANG_EAST, 33'h10000, 0, 0, 0)},
      '{pts(0, 0, 32'hFFFF0000, 0), 1, res(ANG_WEST, 33'h10000, 0, 0, 0)},
      '{pts(5, 7, 5, 32'h00030007), 1, res(ANG_NORTH, 33'h30000, 0, 0, 0)},
      '{pts(5, 7, 5, 32'hFFFD0007), 1, res(ANG_SOUTH, 33'h30000, 0, 0, 0)},
      '{pts(32'h80000000, 0, 32'h7FFFFFFF, 0), 1,
        res(ANG_EAST, 33'hFFFFFFFF, 0, 0, 0)},
      '{pts(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF), 0, '0},
      '{pts(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000), 0, '0},
      '{pts(0, 0, 32'h00030000, 32'h00040000), 0, '0},
      '{pts(0, 0, 32'hFFFFFFFF, 1), 0, '0},
      '{pts(0, 0, 1, 32'hFFFFFFFF), 0, '0},
      '{vec(0, 0, 32'h00020000, ANG_EAST), 1, res(0, 0, 0, 32'h00020000, 0)},
      '{vec(3, 4, 32'h00020000, ANG_NORTH), 1, res(0, 0, 0, 3, 32'h00020004)},
      '{vec(3, 4, 32'h00020000, ANG_WEST), 1, res(0, 0, 0, 32'hFFFE0003, 4)},
      '{vec(3, 4, 32'h00020000, ANG_SOUTH), 1, res(0, 0, 0, 3, 32'hFFFE0004)},
      '{vec(32'h7FFFFFFF, 0, 32'hFFFFFFFF, ANG_EAST), 1,
        res(0, 0, 0, 32'h7FFFFFFF, 0)},
      '{vec(0, 32'h80000000, 32'hFFFFFFFF, ANG_SOUTH), 1,
        res(0, 0, 0, 0, 32'h80000000)},
      '{vec(0, 0, 0, 16'h1234), 1, res(0, 0, 0, 0, 0)},
      '{vec(0, 0, 32'hFFFFFFFF, 16'h2000), 0, '0},
      '{vec(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 16'hFFFF), 0, '0},
      '{vec(0, 0, 32'h00010000, 16'h0001), 0, '0},
      '{vec(0, 0, 32'h00010000, 16'h7FFF), 0, '0},
      '{vec(0, 0, 32'h00010000, 16'hC001), 0, '0}
    };
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[k]) begin
      if (rows[k].typed) begin
        send_typed(rows[k].item, rows[k].want);
      end else begin
        send(rows[k].item);
      end
      if (k % 5 == 0) idle_gap();
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if ($urandom_range(0, 3) == 0) begin
        send(random_item());
        idle_gap();
      end else begin
        send_burst(random_item());
        if (n % 64 == 63) begin
          start <= 1'b0;
          @(negedge clk);
        end
      end
      // drain the pipeline once in the middle
      if (n == N_RANDOM / 2) begin
        start <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
      end
    end
    start <= 1'b0;

    while (expected_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
